[rtl/lkfr_pkg.sv]
// Shared types and constants for the LRU-K frame replacer.
// Depends on nothing; every other file of the block imports it.
package lkfr_pkg;

	localparam int FRAMES  = 64;
	localparam int FRAME_W = 6;
	localparam int COUNT_W = 4;
	localparam int TOTAL_W = 7;

	localparam logic [COUNT_W-1:0] K_RESET   = 4'd2;
	localparam logic [TOTAL_W-1:0] FIU_RESET = 7'd64;

	// Configuration register indexes
	localparam logic CFG_K_THRESHOLD   = 1'b0;
	localparam logic CFG_FRAMES_IN_USE = 1'b1;

	typedef enum logic [1:0] {
		OP_ACCESS    = 2'd0,
		OP_SET_EVICT = 2'd1,
		OP_REMOVE    = 2'd2,
		OP_EVICT     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_RANGE  = 2'd1,
		ST_PINNED = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		TAG_NONE  = 2'd0,
		TAG_HIST  = 2'd1,
		TAG_CACHE = 2'd2
	} tag_t;

	typedef struct packed {
		op_t                op;
		logic [FRAME_W-1:0] frame;
		logic               evictable_flag;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic               victim_valid;
		logic [FRAME_W-1:0] victim_frame;
		logic [TOTAL_W-1:0] evictable_count;
	} out_item_t;

	// Per-frame bookkeeping kept in the frame memory
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               mark;
		tag_t               tag;
	} info_t;

	typedef struct packed {
		info_t              info;
		logic [FRAME_W-1:0] next;
		logic [FRAME_W-1:0] prev;
	} entry_t;

	typedef struct packed {
		logic               en_info;
		logic               en_next;
		logic               en_prev;
		logic [FRAME_W-1:0] addr;
		entry_t             data;
	} mem_wr_t;

	typedef struct packed {
		logic               en;
		logic [FRAME_W-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic [FRAME_W-1:0] head;
		logic [FRAME_W-1:0] tail;
		logic               used;
	} list_t;

endpackage

[rtl/lkfr_mem.sv]
// Frame memory: one synchronous read port, one write port with field enables.
// Valid bits make never-written entries read as count zero, unmarked, untracked.
// Depends on lkfr_pkg.
module lkfr_mem import lkfr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  mem_rd_t            rd,
	input  mem_wr_t            wr,
	output info_t              rd_info,
	output logic [FRAME_W-1:0] rd_next,
	output logic [FRAME_W-1:0] rd_prev
);

	entry_t mem [FRAMES];
	logic   vld_q [FRAMES];
	entry_t rd_data_q;
	logic   rd_vld_q;

	// Write selected fields, read one entry a cycle
	always_ff @(posedge clk) begin
		if (wr.en_info) mem[wr.addr].info <= wr.data.info;
		if (wr.en_next) mem[wr.addr].next <= wr.data.next;
		if (wr.en_prev) mem[wr.addr].prev <= wr.data.prev;
		if (rd.en) rd_data_q <= mem[rd.addr];
	end

	// Track which entries hold written bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) vld_q[i] <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en_info) vld_q[wr.addr] <= 1'b1;
			if (rd.en) rd_vld_q <= vld_q[rd.addr];
		end
	end

	assign rd_info = rd_vld_q ? rd_data_q.info : info_t'('0);
	assign rd_next = rd_data_q.next;
	assign rd_prev = rd_data_q.prev;

endmodule

[rtl/lkfr_seq.sv]
// Sequencer: reads a frame entry, decides, writes back links and bookkeeping.
// Holds both list heads/tails and the evictable total. Depends on lkfr_pkg.
module lkfr_seq import lkfr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COUNT_W-1:0] k_threshold,
	input  logic [TOTAL_W-1:0] frames_in_use,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_item,
	output logic               res_valid,
	input  logic               res_ready,
	output out_item_t          res_item,
	output mem_rd_t            rd,
	output mem_wr_t            wr,
	input  info_t              rd_info,
	input  logic [FRAME_W-1:0] rd_next,
	input  logic [FRAME_W-1:0] rd_prev
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_LOOK = 8'b0000_0010,
		S_WALK = 8'b0000_0100,
		S_WR_P = 8'b0000_1000,
		S_WR_N = 8'b0001_0000,
		S_WR_F = 8'b0010_0000,
		S_WR_H = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	typedef struct packed {
		list_t l;
		logic  do_p;
		logic  do_n;
	} unlink_t;

	// Remove frame x from list l; report which neighbor links need rewriting
	function automatic unlink_t unlink(list_t l, logic [FRAME_W-1:0] x,
			logic [FRAME_W-1:0] p, logic [FRAME_W-1:0] n);
		unlink_t u;
		u.l    = l;
		u.do_p = 1'b0;
		u.do_n = 1'b0;
		if (l.head == x && l.tail == x) begin
			u.l.used = 1'b0;
		end else begin
			if (l.head == x) u.l.head = n;
			else u.do_p = 1'b1;
			if (l.tail == x) u.l.tail = p;
			else u.do_n = 1'b1;
		end
		return u;
	endfunction

	state_t             state_q, state_d;
	in_item_t           item_q, item_d;
	logic [FRAME_W-1:0] cur_q, cur_d;
	logic               walk_cache_q, walk_cache_d;
	list_t              hist_q, hist_d, cache_q, cache_d;
	logic [TOTAL_W-1:0] total_q, total_d;
	out_item_t          res_q, res_d;
	logic [FRAME_W-1:0] p_q, p_d, n_q, n_d, h_q, h_d;
	logic               do_p_q, do_p_d, do_n_q, do_n_d, do_h_q, do_h_d;
	logic               wr_info_q, wr_info_d, wr_links_q, wr_links_d;
	info_t              wf_info_q, wf_info_d;
	logic [FRAME_W-1:0] wf_next_q, wf_next_d;

	unlink_t            uh, uc;
	logic               lv_hist, lv_cache;
	list_t              hist_lv, cache_lv, push_l;
	logic               lv_do_p, lv_do_n;
	logic [COUNT_W-1:0] k_eff, cnt_n;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res_item                 = res_q;
		res_item.evictable_count = total_q;
	end

	// Leave-list results for the entry just read
	always_comb begin
		uh       = unlink(hist_q, cur_q, rd_prev, rd_next);
		uc       = unlink(cache_q, cur_q, rd_prev, rd_next);
		lv_hist  = (rd_info.tag == TAG_HIST);
		lv_cache = (rd_info.tag == TAG_CACHE);
		hist_lv  = lv_hist ? uh.l : hist_q;
		cache_lv = lv_cache ? uc.l : cache_q;
		lv_do_p  = lv_hist ? uh.do_p : (lv_cache ? uc.do_p : 1'b0);
		lv_do_n  = lv_hist ? uh.do_n : (lv_cache ? uc.do_n : 1'b0);
		k_eff    = (k_threshold == '0) ? COUNT_W'(1) : k_threshold;
		cnt_n    = (rd_info.count < k_eff) ? rd_info.count + COUNT_W'(1) : rd_info.count;
	end

	// Next-state logic
	always_comb begin
		state_d      = state_q;
		item_d       = item_q;
		cur_d        = cur_q;
		walk_cache_d = walk_cache_q;
		hist_d       = hist_q;
		cache_d      = cache_q;
		total_d      = total_q;
		res_d        = res_q;
		p_d          = p_q;
		n_d          = n_q;
		h_d          = h_q;
		do_p_d       = do_p_q;
		do_n_d       = do_n_q;
		do_h_d       = do_h_q;
		wr_info_d    = wr_info_q;
		wr_links_d   = wr_links_q;
		wf_info_d    = wf_info_q;
		wf_next_d    = wf_next_q;
		push_l       = cache_lv;
		rd           = '0;
		wr           = '0;

		case (state_q)
			// Accept an item and start its first read, or report an empty evict
			S_IDLE: begin
				if (in_valid) begin
					item_d     = in_item;
					cur_d      = in_item.frame;
					res_d      = '0;
					do_p_d     = 1'b0;
					do_n_d     = 1'b0;
					do_h_d     = 1'b0;
					wr_info_d  = 1'b0;
					wr_links_d = 1'b0;
					if (in_item.op == OP_EVICT) begin
						if (total_q != '0 && hist_q.used) begin
							walk_cache_d = 1'b0;
							cur_d        = hist_q.tail;
							rd.en        = 1'b1;
							rd.addr      = hist_q.tail;
							state_d      = S_WALK;
						end else if (total_q != '0 && cache_q.used) begin
							walk_cache_d = 1'b1;
							cur_d        = cache_q.tail;
							rd.en        = 1'b1;
							rd.addr      = cache_q.tail;
							state_d      = S_WALK;
						end else begin
							res_d.status = ST_EMPTY;
							state_d      = S_DONE;
						end
					end else begin
						rd.en   = 1'b1;
						rd.addr = in_item.frame;
						state_d = S_LOOK;
					end
				end
			end

			// Decide access, set-evictable and remove from the frame entry
			S_LOOK: begin
				state_d = S_DONE;
				if ({1'b0, item_q.frame} >= frames_in_use) begin
					res_d.status = ST_RANGE;
				end else begin
					case (item_q.op)
						OP_ACCESS: begin
							state_d         = S_WR_P;
							wr_info_d       = 1'b1;
							wf_info_d       = rd_info;
							wf_info_d.count = cnt_n;
							p_d             = rd_prev;
							n_d             = rd_next;
							if (cnt_n >= k_eff) begin
								// Leave any list, then push to cache front
								hist_d          = hist_lv;
								do_p_d          = lv_do_p;
								do_n_d          = lv_do_n;
								wf_info_d.tag   = TAG_CACHE;
								wr_links_d      = 1'b1;
								push_l          = cache_lv;
								if (push_l.used) begin
									wf_next_d = push_l.head;
									do_h_d    = 1'b1;
									h_d       = push_l.head;
									push_l.head = cur_q;
								end else begin
									wf_next_d = cur_q;
									push_l    = '{head: cur_q, tail: cur_q, used: 1'b1};
								end
								cache_d = push_l;
							end else if (rd_info.tag == TAG_NONE) begin
								wf_info_d.tag = TAG_HIST;
								wr_links_d    = 1'b1;
								push_l        = hist_q;
								if (push_l.used) begin
									wf_next_d = push_l.head;
									do_h_d    = 1'b1;
									h_d       = push_l.head;
									push_l.head = cur_q;
								end else begin
									wf_next_d = cur_q;
									push_l    = '{head: cur_q, tail: cur_q, used: 1'b1};
								end
								hist_d = push_l;
							end
						end
						OP_SET_EVICT: begin
							if (rd_info.count != '0) begin
								if (!rd_info.mark && item_q.evictable_flag) begin
									total_d = total_q + TOTAL_W'(1);
								end else if (rd_info.mark && !item_q.evictable_flag &&
										total_q != '0) begin
									total_d = total_q - TOTAL_W'(1);
								end
								wf_info_d      = rd_info;
								wf_info_d.mark = item_q.evictable_flag;
								wr_info_d      = 1'b1;
								state_d        = S_WR_P;
							end
						end
						OP_REMOVE: begin
							if (rd_info.count != '0) begin
								if (!rd_info.mark) begin
									res_d.status = ST_PINNED;
								end else begin
									hist_d    = hist_lv;
									cache_d   = cache_lv;
									do_p_d    = lv_do_p;
									do_n_d    = lv_do_n;
									p_d       = rd_prev;
									n_d       = rd_next;
									wf_info_d = '0;
									wr_info_d = 1'b1;
									if (total_q != '0) total_d = total_q - TOTAL_W'(1);
									state_d   = S_WR_P;
								end
							end
						end
						default: ;
					endcase
				end
			end

			// Walk a list from its tail toward its head, one entry a cycle
			S_WALK: begin
				if (rd_info.mark) begin
					res_d.victim_valid = 1'b1;
					res_d.victim_frame = cur_q;
					hist_d    = hist_lv;
					cache_d   = cache_lv;
					do_p_d    = lv_do_p;
					do_n_d    = lv_do_n;
					p_d       = rd_prev;
					n_d       = rd_next;
					wf_info_d = '0;
					wr_info_d = 1'b1;
					if (total_q != '0) total_d = total_q - TOTAL_W'(1);
					state_d   = S_WR_P;
				end else if (cur_q == (walk_cache_q ? cache_q.head : hist_q.head)) begin
					if (!walk_cache_q && cache_q.used) begin
						walk_cache_d = 1'b1;
						cur_d        = cache_q.tail;
						rd.en        = 1'b1;
						rd.addr      = cache_q.tail;
					end else begin
						res_d.status = ST_EMPTY;
						state_d      = S_DONE;
					end
				end else begin
					cur_d   = rd_prev;
					rd.en   = 1'b1;
					rd.addr = rd_prev;
				end
			end

			// Point the predecessor past the leaving frame
			S_WR_P: begin
				wr.en_next   = do_p_q;
				wr.addr      = p_q;
				wr.data.next = n_q;
				state_d      = S_WR_N;
			end

			// Point the successor back past the leaving frame
			S_WR_N: begin
				wr.en_prev   = do_n_q;
				wr.addr      = n_q;
				wr.data.prev = p_q;
				state_d      = S_WR_F;
			end

			// Write the frame's own entry
			S_WR_F: begin
				wr.en_info   = wr_info_q;
				wr.en_next   = wr_links_q;
				wr.en_prev   = wr_links_q;
				wr.addr      = cur_q;
				wr.data.info = wf_info_q;
				wr.data.next = wf_next_q;
				wr.data.prev = cur_q;
				state_d      = S_WR_H;
			end

			// Link the old head back to the new front frame
			S_WR_H: begin
				wr.en_prev   = do_h_q;
				wr.addr      = h_q;
				wr.data.prev = cur_q;
				state_d      = S_DONE;
			end

			// Hand the result to the output register
			S_DONE: begin
				if (res_ready) state_d = S_IDLE;
			end

			default: state_d = S_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hist_q  <= '0;
			cache_q <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			hist_q  <= hist_d;
			cache_q <= cache_d;
			total_q <= total_d;
		end
	end

	// Working registers of the current item
	always_ff @(posedge clk) begin
		item_q       <= item_d;
		cur_q        <= cur_d;
		walk_cache_q <= walk_cache_d;
		res_q        <= res_d;
		p_q          <= p_d;
		n_q          <= n_d;
		h_q          <= h_d;
		do_p_q       <= do_p_d;
		do_n_q       <= do_n_d;
		do_h_q       <= do_h_d;
		wr_info_q    <= wr_info_d;
		wr_links_q   <= wr_links_d;
		wf_info_q    <= wf_info_d;
		wf_next_q    <= wf_next_d;
	end

endmodule

[rtl/lru_k_frame_replacer.sv]
// LRU-K frame replacer, top level: configuration registers, sequencer,
// frame memory and output register. Depends on lkfr_pkg, lkfr_mem, lkfr_seq.
//
// Takes one item at a time. Access, set-evictable and remove pass through
// accept and decide, then, when the frame entry is written, four write slots,
// and then the result state. Evict walks the history list and then the cache
// list from the tail, one frame entry read per cycle through the single memory
// port, then, when a victim is found, uses the same four write slots and the
// result state. A finished item waits in the output register while the next
// item is accepted. Configuration writes take effect at once and are meant
// for an idle block.
module lru_k_frame_replacer import lkfr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [6:0]   cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  in_item_t     in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output out_item_t    out_data
);

	logic [COUNT_W-1:0] k_threshold_q;
	logic [TOTAL_W-1:0] frames_in_use_q;
	logic               out_valid_q;
	out_item_t          out_data_q;
	logic               res_valid, res_ready;
	out_item_t          res_item;
	mem_rd_t            rd;
	mem_wr_t            wr;
	info_t              rd_info;
	logic [FRAME_W-1:0] rd_next, rd_prev;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_threshold_q   <= K_RESET;
			frames_in_use_q <= FIU_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_K_THRESHOLD:   k_threshold_q   <= cfg_data[COUNT_W-1:0];
				CFG_FRAMES_IN_USE: frames_in_use_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lkfr_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.k_threshold   (k_threshold_q),
		.frames_in_use (frames_in_use_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_item       (in_data),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res_item      (res_item),
		.rd            (rd),
		.wr            (wr),
		.rd_info       (rd_info),
		.rd_next       (rd_next),
		.rd_prev       (rd_prev)
	);

	lkfr_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd),
		.wr      (wr),
		.rd_info (rd_info),
		.rd_next (rd_next),
		.rd_prev (rd_prev)
	);

	// Output register: load when empty or being drained
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_data_q <= res_item;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[verif/lru_k_frame_replacer_tb.sv]
// Testbench for the LRU-K frame replacer: directed and random items with a
// scoreboard that predicts each result. Depends on lkfr_pkg and the block.
`timescale 1ns / 100ps

module lru_k_frame_replacer_tb;
	import lkfr_pkg::*;

	// Expected results and the replacer state that produces them
	class replacer_scoreboard;
		logic [3:0] k_reg;
		logic [6:0] fiu_reg;
		logic [3:0] cnt [FRAMES];
		logic       mark [FRAMES];
		tag_t       tag [FRAMES];
		logic [5:0] nxt [FRAMES];
		logic [5:0] prv [FRAMES];
		list_t      hist;
		list_t      cache;
		logic [6:0] total;
		out_item_t  pending [$];
		int         errors;

		function new();
			k_reg = K_RESET;
			fiu_reg = FIU_RESET;
			for (int i = 0; i < FRAMES; i++) begin
				cnt[i] = 0; mark[i] = 0; tag[i] = TAG_NONE;
				nxt[i] = 0; prv[i] = 0;
			end
			hist = '0;
			cache = '0;
			total = 0;
			errors = 0;
		endfunction

		function void write_reg(logic idx, logic [6:0] val);
			if (idx == CFG_K_THRESHOLD) k_reg = val[3:0];
			else fiu_reg = val;
		endfunction

		function void unlink(ref list_t l, input logic [5:0] f);
			logic [5:0] p, n;
			p = prv[f];
			n = nxt[f];
			if (l.head == f && l.tail == f) begin
				l.used = 0;
				return;
			end
			if (l.head == f) l.head = n;
			else nxt[p] = n;
			if (l.tail == f) l.tail = p;
			else prv[n] = p;
		endfunction

		function void add_front(ref list_t l, input logic [5:0] f);
			prv[f] = f;
			nxt[f] = f;
			if (!l.used) begin
				l.head = f; l.tail = f; l.used = 1;
				return;
			end
			nxt[f] = l.head;
			prv[l.head] = f;
			l.head = f;
		endfunction

		function void drop_from_list(logic [5:0] f);
			if (tag[f] == TAG_HIST) unlink(hist, f);
			else if (tag[f] == TAG_CACHE) unlink(cache, f);
			tag[f] = TAG_NONE;
		endfunction

		function void clear_frame(logic [5:0] f);
			drop_from_list(f);
			cnt[f] = 0;
			mark[f] = 0;
			if (total > 0) total--;
		endfunction

		function bit scan_tail(list_t l, output logic [5:0] v);
			logic [5:0] f;
			v = 0;
			if (!l.used) return 0;
			f = l.tail;
			for (int s = 0; s < FRAMES; s++) begin
				if (mark[f]) begin
					v = f;
					return 1;
				end
				if (f == l.head) break;
				f = prv[f];
			end
			return 0;
		endfunction

		// Note an accepted item and queue its result
		function void note_item(in_item_t it);
			out_item_t r;
			logic [4:0] k;
			logic [6:0] lim;
			logic [5:0] f, v;
			bit found;
			r = '0;
			r.status = ST_OK;
			f = it.frame;
			k = (k_reg == 0) ? 5'd1 : {1'b0, k_reg};
			lim = (fiu_reg < FRAMES) ? fiu_reg : 7'(FRAMES);
			if (it.op == OP_EVICT) begin
				found = 0;
				if (total != 0) begin
					found = scan_tail(hist, v);
					if (!found) found = scan_tail(cache, v);
				end
				if (found) begin
					clear_frame(v);
					r.victim_valid = 1;
					r.victim_frame = v;
				end else r.status = ST_EMPTY;
			end else if ({1'b0, f} >= lim) begin
				r.status = ST_RANGE;
			end else if (it.op == OP_ACCESS) begin
				if (cnt[f] < k) cnt[f]++;
				if (cnt[f] >= k) begin
					drop_from_list(f);
					add_front(cache, f);
					tag[f] = TAG_CACHE;
				end else if (tag[f] == TAG_NONE) begin
					add_front(hist, f);
					tag[f] = TAG_HIST;
				end
			end else if (it.op == OP_SET_EVICT) begin
				if (cnt[f] != 0) begin
					if (!mark[f] && it.evictable_flag) total++;
					else if (mark[f] && !it.evictable_flag && total > 0) total--;
					mark[f] = it.evictable_flag;
				end
			end else begin
				if (cnt[f] != 0) begin
					if (!mark[f]) r.status = ST_PINNED;
					else clear_frame(f);
				end
			end
			r.evictable_count = total;
			pending.push_back(r);
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(out_item_t got);
			out_item_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: actual %h", $realtime, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$display("%0t status: expected %0d actual %0d", $realtime, e.status, got.status);
				errors++;
			end
			if (got.victim_valid !== e.victim_valid) begin
				$display("%0t victim_valid: expected %0d actual %0d", $realtime,
					e.victim_valid, got.victim_valid);
				errors++;
			end
			if (got.victim_frame !== e.victim_frame) begin
				$display("%0t victim_frame: expected %0d actual %0d", $realtime,
					e.victim_frame, got.victim_frame);
				errors++;
			end
			if (got.evictable_count !== e.evictable_count) begin
				$display("%0t evictable_count: expected %0d actual %0d", $realtime,
					e.evictable_count, got.evictable_count);
				errors++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 1000000;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      cfg_we = 0;
	logic      cfg_index = 0;
	logic [6:0] cfg_data = 0;
	logic      in_valid = 0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 0;
	out_item_t out_data;

	replacer_scoreboard sb;
	int  cycle_count = 0;
	bit  calm = 0;
	bit  hold_off = 0;
	logic [6:0] frame_span = 64;

	lru_k_frame_replacer u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Sample the output handshake at the rising edge; stop at the cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: random stalls, always ready when calm, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_off) out_ready <= 0;
		else if (calm) out_ready <= 1;
		else out_ready <= ($urandom_range(99) >= 34);
	end

	// Offer one item at a falling edge, after random idle gaps unless calm, and wait for it to be accepted
	task automatic send_item(in_item_t it);
		@(negedge clk);
		if (!calm) begin
			while ($urandom_range(99) < 34) begin
				in_valid <= 0;
				@(negedge clk);
			end
		end
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
	endtask

	// Drop valid once no further item follows
	task automatic stop_items();
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic send_op(op_t op, int f, bit flag);
		in_item_t it;
		it.op = op;
		it.frame = 6'(f);
		it.evictable_flag = flag;
		send_item(it);
	endtask

	// Write a register once every result is back and the block is quiet
	task automatic write_reg(logic idx, int val);
		stop_items();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= 7'(val);
		@(posedge clk);
		sb.write_reg(idx, 7'(val));
		@(negedge clk);
		cfg_we <= 0;
		if (idx == CFG_FRAMES_IN_USE) frame_span = (val == 0) ? 7'd1 : 7'(val);
	endtask

	// Mostly accesses and marks on a small working set, with removes and evicts mixed in
	task automatic random_item();
		int r, f;
		r = $urandom_range(99);
		if ($urandom_range(9) == 0) f = $urandom_range(63);
		else f = $urandom_range((frame_span > 64 ? 64 : frame_span) - 1);
		if (r < 40) send_op(OP_ACCESS, f, 1'($urandom_range(1)));
		else if (r < 65) send_op(OP_SET_EVICT, f, $urandom_range(99) < 70);
		else if (r < 78) send_op(OP_REMOVE, f, 1'($urandom_range(1)));
		else send_op(OP_EVICT, $urandom_range(63), 1'($urandom_range(1)));
	endtask

	initial begin
		sb = new();
		repeat (3) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: empty evict, range edges, unknown frames, pinned remove
		send_op(OP_EVICT, 63, 1);
		send_op(OP_ACCESS, 63, 1);
		send_op(OP_ACCESS, 0, 0);
		send_op(OP_SET_EVICT, 5, 1);
		send_op(OP_REMOVE, 7, 0);
		send_op(OP_REMOVE, 0, 0);
		send_op(OP_ACCESS, 0, 0);
		send_op(OP_ACCESS, 0, 0);
		send_op(OP_SET_EVICT, 0, 1);
		send_op(OP_SET_EVICT, 63, 1);
		send_op(OP_SET_EVICT, 63, 0);
		send_op(OP_EVICT, 0, 0);
		send_op(OP_SET_EVICT, 63, 1);
		send_op(OP_REMOVE, 63, 1);
		send_op(OP_EVICT, 0, 0);
		write_reg(CFG_FRAMES_IN_USE, 10);
		send_op(OP_ACCESS, 10, 0);
		send_op(OP_ACCESS, 9, 0);
		write_reg(CFG_FRAMES_IN_USE, 0);
		send_op(OP_ACCESS, 0, 0);
		write_reg(CFG_FRAMES_IN_USE, 127);
		write_reg(CFG_K_THRESHOLD, 0);
		send_op(OP_ACCESS, 1, 0);
		send_op(OP_SET_EVICT, 1, 1);
		send_op(OP_EVICT, 0, 0);

		// Random phases over several settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_K_THRESHOLD, 2); write_reg(CFG_FRAMES_IN_USE, 8); end
				1: begin write_reg(CFG_K_THRESHOLD, 15); write_reg(CFG_FRAMES_IN_USE, 64); end
				2: begin write_reg(CFG_K_THRESHOLD, 1); write_reg(CFG_FRAMES_IN_USE, 1); end
				3: begin write_reg(CFG_K_THRESHOLD, 3); write_reg(CFG_FRAMES_IN_USE, 16); end
				4: begin write_reg(CFG_K_THRESHOLD, 4); write_reg(CFG_FRAMES_IN_USE, 100); end
				default: begin write_reg(CFG_K_THRESHOLD, 2); write_reg(CFG_FRAMES_IN_USE, 12); end
			endcase
			calm = (ph == 3);
			for (int i = 0; i < 240; i++) random_item();
			calm = 0;
		end

		// Hold the receiver off while items keep coming, until input stalls
		fork
			begin
				hold_off = 1;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 12; i++) random_item();
		join
		stop_items();

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
